// File: rtl/text_terminal_cell_buffer_top_defines.svh
// Assertion helpers used by the datapath of the character-cell console store.
`ifndef TEXT_TERMINAL_CELL_BUFFER_TOP_DEFINES_SVH
`define TEXT_TERMINAL_CELL_BUFFER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TTCB_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttcb: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttcb: next-cycle check failed");

`endif

// File: rtl/ttcb_pkg.sv
package ttcb_pkg;

   // Field widths of the request, response and register port
   localparam int REQ_TYPE_W     = 1;
   localparam int CHAR_W         = 8;
   localparam int READ_COL_W     = 7;
   localparam int READ_ROW_W     = 6;
   localparam int DIRTY_COL_W    = 7;
   localparam int DIRTY_ROW_W    = 6;
   localparam int CURSOR_COL_W   = 8;
   localparam int CURSOR_ROW_W   = 6;
   localparam int COLUMNS_USED_W = 8;
   localparam int ROWS_USED_W    = 7;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 8;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0]    CSR_COLUMNS_USED   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0]    CSR_ROWS_USED      = 1'b1;
   localparam logic [COLUMNS_USED_W-1:0] COLUMNS_USED_RESET = 8'd80;
   localparam logic [ROWS_USED_W-1:0]    ROWS_USED_RESET    = 7'd25;

   // Request kinds and control characters
   localparam logic [REQ_TYPE_W-1:0] REQ_READ     = 1'b1;
   localparam logic [CHAR_W-1:0]     CH_NUL       = 8'd0;
   localparam logic [CHAR_W-1:0]     CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0]     CH_BACKSPACE = 8'd8;

   typedef enum logic [2:0] {
      OP_READ,
      OP_NUL,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_PRINT
   } op_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic norm;
      logic read;
      logic adv_line;
      logic backspace;
      logic scroll_step;
      logic write_cell;
      logic finish;
   } ttcb_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic        clear_last;
      logic        top_ge_rows;
      op_kind_type op;
      logic        at_last_row;
      logic        col_past_end;
      logic        scroll_last;
      logic        rsp_free;
   } ttcb_status_type;

endpackage

// File: rtl/ttcb_if.sv
interface ttcb_req_if import ttcb_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CHAR_W-1:0]     char_code;
   logic [READ_COL_W-1:0] read_col;
   logic [READ_ROW_W-1:0] read_row;

   modport source (output valid, req_type, char_code, read_col, read_row, input ready);
   modport sink (input valid, req_type, char_code, read_col, read_row, output ready);
endinterface

interface ttcb_rsp_if import ttcb_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CHAR_W-1:0]       read_char;
   logic                    cell_dirty;
   logic [DIRTY_COL_W-1:0]  dirty_col;
   logic [DIRTY_ROW_W-1:0]  dirty_row;
   logic                    full_redraw;
   logic [CURSOR_COL_W-1:0] cursor_col;
   logic [CURSOR_ROW_W-1:0] cursor_row;

   modport source (output valid, read_char, cell_dirty, dirty_col, dirty_row, full_redraw,
                   cursor_col, cursor_row, input ready);
   modport sink (input valid, read_char, cell_dirty, dirty_col, dirty_row, full_redraw,
                 cursor_col, cursor_row, output ready);
endinterface

// File: rtl/ttcb_ram.sv
module ttcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wr_data,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port: write or registered read at one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ttcb_ctrl.sv
module ttcb_ctrl import ttcb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ttcb_status_type status,
   output ttcb_cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Sequence one item: execute, optional line clear, optional cell write, response
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.top_ge_rows) begin
               // Bring the top line back under the row count first
               cmd.norm = 1'b1;
            end else begin
               unique case (status.op)
                  OP_READ: begin
                     cmd.read = 1'b1;
                     state_in = ST_FINISH;
                  end
                  OP_NUL: begin
                     state_in = ST_FINISH;
                  end
                  OP_NEWLINE: begin
                     cmd.adv_line = 1'b1;
                     state_in     = status.at_last_row ? ST_SCROLL : ST_FINISH;
                  end
                  OP_BACKSPACE: begin
                     cmd.backspace = 1'b1;
                     state_in      = ST_WRITE;
                  end
                  OP_PRINT: begin
                     if (status.col_past_end) begin
                        cmd.adv_line = 1'b1;
                        state_in     = status.at_last_row ? ST_SCROLL : ST_WRITE;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) begin
               state_in = (status.op == OP_PRINT) ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            cmd.write_cell = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: rtl/ttcb_datapath.sv
`include "text_terminal_cell_buffer_top_defines.svh"

module ttcb_datapath import ttcb_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ttcb_cmd_type              cmd,
   output ttcb_status_type           status,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic [REQ_TYPE_W-1:0]     req_type,
   input  logic [CHAR_W-1:0]         char_code,
   input  logic [READ_COL_W-1:0]     read_col,
   input  logic [READ_ROW_W-1:0]     read_row,
   ttcb_rsp_if.source                rsp
);

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W  = $clog2(MAX_COLS + 1);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int RW     = RCNT_W + 1;

   // Configuration
   logic [COLUMNS_USED_W-1:0] cols_used_ff, cols_used_in;
   logic [ROWS_USED_W-1:0]    rows_used_ff, rows_used_in;
   logic [CNT_W-1:0]          cols_eff;
   logic [RCNT_W-1:0]         rows_eff;

   // Console state
   logic [ROW_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0] cursor_line_ff, cursor_line_in;
   logic [COL_W-1:0] scroll_cnt_ff, scroll_cnt_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;

   // Captured request
   logic [REQ_TYPE_W-1:0] req_type_ff, req_type_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic [READ_COL_W-1:0] read_col_ff, read_col_in;
   logic [READ_ROW_W-1:0] read_row_ff, read_row_in;

   // Per-item results
   logic                   dirty_ff, dirty_in;
   logic [DIRTY_COL_W-1:0] dcol_ff, dcol_in;
   logic [DIRTY_ROW_W-1:0] drow_ff, drow_in;
   logic                   redraw_ff, redraw_in;
   logic                   rd_hit_ff, rd_hit_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_dirty_ff, rsp_dirty_in;
   logic [DIRTY_COL_W-1:0]  rsp_dcol_ff, rsp_dcol_in;
   logic [DIRTY_ROW_W-1:0]  rsp_drow_ff, rsp_drow_in;
   logic                    rsp_redraw_ff, rsp_redraw_in;
   logic [CURSOR_COL_W-1:0] rsp_ccol_ff, rsp_ccol_in;
   logic [CURSOR_ROW_W-1:0] rsp_crow_ff, rsp_crow_in;

   op_kind_type      op;
   logic             at_last_row;
   logic             scroll_last;
   logic             read_in_range;
   logic [ROW_W-1:0] line_sat;
   logic [CNT_W-1:0] col_sat;
   logic [ROW_W-1:0] sel_row;
   logic [COL_W-1:0] sel_col;
   logic [RW-1:0]    phys_sum;
   logic [ROW_W-1:0] phys;
   logic [AW-1:0]    cell_addr;
   logic             ram_we;
   logic             ram_re;
   logic [AW-1:0]    ram_addr;
   logic [CHAR_W-1:0] ram_wdata;
   logic [CHAR_W-1:0] ram_rdata;

   // Clamp the register values to the usable range
   always_comb begin
      if (cols_used_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (int'(cols_used_ff) > MAX_COLS) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(cols_used_ff);
      end
      if (rows_used_ff == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (int'(rows_used_ff) > MAX_ROWS) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(rows_used_ff);
      end
   end

   // Register writes
   always_comb begin
      cols_used_in = cols_used_ff;
      rows_used_in = rows_used_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS_USED: cols_used_in = csr_wdata[COLUMNS_USED_W-1:0];
            CSR_ROWS_USED:    rows_used_in = csr_wdata[ROWS_USED_W-1:0];
            default:          cols_used_in = cols_used_ff;
         endcase
      end
   end

   // Decode the held request
   always_comb begin
      if (req_type_ff == REQ_READ) begin
         op = OP_READ;
      end else begin
         unique case (char_ff)
            CH_NUL:       op = OP_NUL;
            CH_NEWLINE:   op = OP_NEWLINE;
            CH_BACKSPACE: op = OP_BACKSPACE;
            default:      op = OP_PRINT;
         endcase
      end
   end

   assign at_last_row   = (RW'(cursor_line_ff) + RW'(1)) >= RW'(rows_eff);
   assign scroll_last   = (CNT_W'(scroll_cnt_ff) == (cols_eff - CNT_W'(1)));
   assign read_in_range = (int'(read_col_ff) < int'(cols_eff)) &&
                          (int'(read_row_ff) < int'(rows_eff));
   assign line_sat = (RW'(cursor_line_ff) >= RW'(rows_eff)) ?
                     ROW_W'(rows_eff - RCNT_W'(1)) : cursor_line_ff;
   assign col_sat  = (cursor_col_ff > cols_eff) ? cols_eff : cursor_col_ff;

   always_comb begin
      status              = '0;
      status.clear_last   = (clr_cnt_ff == AW'(DEPTH - 1));
      status.top_ge_rows  = (RW'(top_ff) >= RW'(rows_eff));
      status.op           = op;
      status.at_last_row  = at_last_row;
      status.col_past_end = (cursor_col_ff >= cols_eff);
      status.scroll_last  = scroll_last;
      status.rsp_free     = !rsp_valid_ff || rsp.ready;
   end

   // Map a screen cell onto the ring of physical lines
   always_comb begin
      sel_row = cursor_line_ff;
      sel_col = COL_W'(cursor_col_ff);
      if (cmd.read) begin
         sel_row = ROW_W'(read_row_ff);
         sel_col = COL_W'(read_col_ff);
      end else if (cmd.scroll_step) begin
         sel_row = '0;
         sel_col = scroll_cnt_ff;
      end
   end

   assign phys_sum  = RW'(top_ff) + RW'(sel_row);
   assign phys      = (phys_sum >= RW'(rows_eff)) ? ROW_W'(phys_sum - RW'(rows_eff)) :
                                                    ROW_W'(phys_sum);
   assign cell_addr = (AW'(phys) * AW'(MAX_COLS)) + AW'(sel_col);

   assign ram_we    = cmd.clear_step || cmd.scroll_step || cmd.write_cell;
   assign ram_re    = cmd.read && read_in_range;
   assign ram_addr  = cmd.clear_step ? clr_cnt_ff : cell_addr;
   assign ram_wdata = (cmd.write_cell && (op == OP_PRINT)) ? char_ff : '0;

   ttcb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Cursor and top line updates
   always_comb begin
      cursor_col_in  = cursor_col_ff;
      cursor_line_in = cursor_line_ff;
      top_in         = top_ff;
      if (cmd.accept) begin
         cursor_col_in  = col_sat;
         cursor_line_in = line_sat;
      end else if (cmd.norm) begin
         top_in = ROW_W'(RW'(top_ff) - RW'(rows_eff));
      end else if (cmd.adv_line) begin
         cursor_col_in = '0;
         if (!at_last_row) begin
            cursor_line_in = cursor_line_ff + ROW_W'(1);
         end
      end else if (cmd.backspace) begin
         if (cursor_col_ff == '0) begin
            if (cursor_line_ff != '0) begin
               cursor_col_in  = cols_eff - CNT_W'(1);
               cursor_line_in = cursor_line_ff - ROW_W'(1);
            end
         end else begin
            cursor_col_in = cursor_col_ff - CNT_W'(1);
         end
      end else if (cmd.scroll_step) begin
         if (scroll_last) begin
            top_in = ((RW'(top_ff) + RW'(1)) >= RW'(rows_eff)) ? '0 : top_ff + ROW_W'(1);
         end
      end else if (cmd.write_cell && (op == OP_PRINT)) begin
         cursor_col_in = cursor_col_ff + CNT_W'(1);
      end
   end

   // Sweep counters for the reset clear and the line clear
   always_comb begin
      clr_cnt_in    = cmd.clear_step ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      scroll_cnt_in = scroll_cnt_ff;
      if (cmd.scroll_step) begin
         scroll_cnt_in = scroll_last ? '0 : scroll_cnt_ff + COL_W'(1);
      end
   end

   // Capture the request and collect the results of this item
   always_comb begin
      req_type_in = req_type_ff;
      char_in     = char_ff;
      read_col_in = read_col_ff;
      read_row_in = read_row_ff;
      dirty_in    = dirty_ff;
      dcol_in     = dcol_ff;
      drow_in     = drow_ff;
      redraw_in   = redraw_ff;
      rd_hit_in   = rd_hit_ff;
      if (cmd.accept) begin
         req_type_in = req_type;
         char_in     = char_code;
         read_col_in = read_col;
         read_row_in = read_row;
         dirty_in    = 1'b0;
         dcol_in     = '0;
         drow_in     = '0;
         redraw_in   = 1'b0;
         rd_hit_in   = 1'b0;
      end
      if (cmd.read) begin
         rd_hit_in = read_in_range;
      end
      if (cmd.scroll_step && scroll_last) begin
         redraw_in = 1'b1;
      end
      if (cmd.write_cell) begin
         dirty_in = 1'b1;
         dcol_in  = DIRTY_COL_W'(cursor_col_ff);
         drow_in  = DIRTY_ROW_W'(cursor_line_ff);
      end
   end

   // Output register: load on finish, drop on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      rsp_dcol_in   = rsp_dcol_ff;
      rsp_drow_in   = rsp_drow_ff;
      rsp_redraw_in = rsp_redraw_ff;
      rsp_ccol_in   = rsp_ccol_ff;
      rsp_crow_in   = rsp_crow_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = rd_hit_ff ? ram_rdata : '0;
         rsp_dirty_in  = dirty_ff;
         rsp_dcol_in   = dcol_ff;
         rsp_drow_in   = drow_ff;
         rsp_redraw_in = redraw_ff;
         rsp_ccol_in   = CURSOR_COL_W'(cursor_col_ff);
         rsp_crow_in   = CURSOR_ROW_W'(cursor_line_ff);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_used_ff   <= COLUMNS_USED_RESET;
         rows_used_ff   <= ROWS_USED_RESET;
         top_ff         <= '0;
         cursor_col_ff  <= '0;
         cursor_line_ff <= '0;
         scroll_cnt_ff  <= '0;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cols_used_ff   <= cols_used_in;
         rows_used_ff   <= rows_used_in;
         top_ff         <= top_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_line_ff <= cursor_line_in;
         scroll_cnt_ff  <= scroll_cnt_in;
         clr_cnt_ff     <= clr_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      char_ff       <= char_in;
      read_col_ff   <= read_col_in;
      read_row_ff   <= read_row_in;
      dirty_ff      <= dirty_in;
      dcol_ff       <= dcol_in;
      drow_ff       <= drow_in;
      redraw_ff     <= redraw_in;
      rd_hit_ff     <= rd_hit_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_dirty_ff  <= rsp_dirty_in;
      rsp_dcol_ff   <= rsp_dcol_in;
      rsp_drow_ff   <= rsp_drow_in;
      rsp_redraw_ff <= rsp_redraw_in;
      rsp_ccol_ff   <= rsp_ccol_in;
      rsp_crow_ff   <= rsp_crow_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_char   = rsp_char_ff;
   assign rsp.cell_dirty  = rsp_dirty_ff;
   assign rsp.dirty_col   = rsp_dcol_ff;
   assign rsp.dirty_row   = rsp_drow_ff;
   assign rsp.full_redraw = rsp_redraw_ff;
   assign rsp.cursor_col  = rsp_ccol_ff;
   assign rsp.cursor_row  = rsp_crow_ff;

   // A cell write always lands inside the visible columns
   `TTCB_ASSERT_HOLDS(a_write_in_row, clock, reset, cmd.write_cell, cursor_col_ff < cols_eff)
   // Line clearing only happens with the cursor on the last row
   `TTCB_ASSERT_HOLDS(a_scroll_last_row, clock, reset, cmd.scroll_step, at_last_row)
   // A new response never overwrites one that has not been taken
   `TTCB_ASSERT_HOLDS(a_finish_free, clock, reset, cmd.finish, !rsp_valid_ff || rsp.ready)
   `TTCB_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

// File: rtl/text_terminal_cell_buffer_top.sv
// Channel   Direction  Carries
// req_ch    in         req_type, char_code, read_col, read_row
// rsp_ch    out        read_char, cell_dirty, dirty_col, dirty_row, full_redraw, cursor
// csr_*     in         columns_used (index 0), rows_used (index 1)
//
// After reset the cell memory is cleared one cell a cycle, all MAX_COLS*MAX_ROWS cells
// (8192 at the defaults), with req_ch.ready low; register writes are taken meanwhile.
// One item at a time: read, ignored and newline items go through execute and response,
// printable and backspace items through execute, a cell write and response.
// A scroll adds a line clear, one visible column per step; a top line left beyond a
// shrunk row count adds row-count subtractions first. A stalled response holds the block.
module text_terminal_cell_buffer_top import ttcb_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   ttcb_req_if.sink               req_ch,
   ttcb_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ttcb_cmd_type    cmd;
   ttcb_status_type status;
   logic            req_ready;

   ttcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttcb_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_type  (req_ch.req_type),
      .char_code (req_ch.char_code),
      .read_col  (req_ch.read_col),
      .read_row  (req_ch.read_row),
      .rsp       (rsp_ch)
   );

   assign req_ch.ready = req_ready;

endmodule
